// File: design/qmn_pkg.sv
// Shared constants and types for the quaternion product and renormalisation pipeline.
// Depends on nothing; imported by quaternion_multiply_normalize.
package qmn_pkg;

    // Component format
    localparam int CW = 16;
    localparam int FB = 14;

    // Partial product scaling and sum widths
    localparam int PRE_SHIFT = (2 * CW > 32) ? (2 * CW - 32) : 0;
    localparam int PROD_W    = 2 * CW - PRE_SHIFT;
    localparam int SUM_W     = PROD_W + 2;
    localparam int MSB_W     = $clog2(SUM_W);

    // The largest block-scaled magnitude sits in [2^29, 2^30); the others lie below 2^30
    localparam int NORM_W   = 30;
    localparam int NORM_TOP = NORM_W - 1;
    localparam int SH_W     = (SUM_W > NORM_W) ? SUM_W : NORM_W;

    // Sum of squares and square root
    localparam int SQ_W   = 2 * NORM_W;
    localparam int SSUM_W = SQ_W + 2;
    localparam int ROOT_W = SSUM_W / 2;
    localparam int REM_W  = SSUM_W + 1;

    // Rounded division
    localparam int DIV_W = ROOT_W + FB + 1;
    localparam int Q_W   = FB + 1;

    // Saturation limit: min(2^FB, 2^(CW-1) - 1)
    localparam longint LIMIT_L = ((64'sd1 << FB) < ((64'sd1 << (CW - 1)) - 1)) ?
                                 (64'sd1 << FB) : ((64'sd1 << (CW - 1)) - 1);
    localparam logic [Q_W-1:0] LIMIT_Q = Q_W'(LIMIT_L);

    // Pipeline depth: products, sums, leading one, shift, squares, two adds,
    // one stage per root bit, numerator, one stage per quotient bit, output
    localparam int NST    = 7 + ROOT_W + 1 + Q_W + 1;
    localparam int ST_DIV = 7 + ROOT_W;

    typedef logic [3:0][NORM_W-1:0] norm_vec_t;

    typedef struct packed {
        logic [3:0] neg;
        logic       zero;
        norm_vec_t  m;
    } carry_t;

endpackage

// File: design/quaternion_multiply_normalize.sv
// Hamilton product of two Q1.14 quaternions, renormalised to unit length.
// Depends on qmn_pkg for widths, stage counts and the carried item type.
//
//  channel | ports           | tdata (low bit first)                  | tuser
//  --------+-----------------+----------------------------------------+------------
//  input   | s_tvalid/tready | left_w,x,y,z, right_w,x,y,z (16b each) | -
//  output  | m_tvalid/tready | prod_w, prod_x, prod_y, prod_z (16b)   | zero_length
//
// One item enters every cycle while the output is not stalled; the pipeline holds
// 7 arithmetic stages, 31 square-root stages (one root bit each),
// a numerator stage, 15 division stages (one quotient bit each) and the output.
// Reset (aresetn low, synchronous) clears the valid bits only.
// A stall on the output freezes the whole pipeline; nothing is lost or repeated.
module quaternion_multiply_normalize
    import qmn_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [127:0]   s_tdata,   // left_w, left_x, left_y, left_z, right_w, .. right_z
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [63:0]    m_tdata,   // prod_w, prod_x, prod_y, prod_z
    output logic           m_tuser    // zero_length
);

    logic           adv;
    logic [NST-1:0] v_reg;

    // Advance everything when the output register is free or being taken
    assign adv      = !v_reg[NST-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = v_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[NST-2:0], s_tvalid};
        end
    end

    // ---------------- stage 1: sixteen partial products ----------------
    logic signed [PROD_W-1:0] pr_reg  [4][4];
    logic signed [PROD_W-1:0] pr_next [4][4];

    always_comb begin
        logic signed [CW-1:0]   a;
        logic signed [CW-1:0]   b;
        logic signed [2*CW-1:0] p;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                a = signed'(s_tdata[i*CW +: CW]);
                b = signed'(s_tdata[(4+j)*CW +: CW]);
                p = a * b;
                p = p >>> PRE_SHIFT;
                pr_next[i][j] = p[PROD_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) pr_reg <= pr_next;
    end

    // ---------------- stage 2: product components, sign and magnitude ----------------
    logic [SUM_W-1:0] mag2_reg [4];
    logic [3:0]       neg2_reg;
    logic [SUM_W-1:0] mag2_next [4];
    logic [3:0]       neg2_next;

    function automatic logic signed [SUM_W-1:0] sx(input logic signed [PROD_W-1:0] v);
        return SUM_W'(v);
    endfunction

    always_comb begin
        logic signed [SUM_W-1:0] pc [4];
        pc[0] = sx(pr_reg[0][0]) - sx(pr_reg[1][1]) - sx(pr_reg[2][2]) - sx(pr_reg[3][3]);
        pc[1] = sx(pr_reg[0][1]) + sx(pr_reg[1][0]) + sx(pr_reg[2][3]) - sx(pr_reg[3][2]);
        pc[2] = sx(pr_reg[0][2]) - sx(pr_reg[1][3]) + sx(pr_reg[2][0]) + sx(pr_reg[3][1]);
        pc[3] = sx(pr_reg[0][3]) + sx(pr_reg[1][2]) - sx(pr_reg[2][1]) + sx(pr_reg[3][0]);
        for (int k = 0; k < 4; k++) begin
            neg2_next[k] = pc[k][SUM_W-1];
            mag2_next[k] = pc[k][SUM_W-1] ? SUM_W'(-pc[k]) : SUM_W'(pc[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mag2_reg <= mag2_next;
            neg2_reg <= neg2_next;
        end
    end

    // ---------------- stage 3: leading one of the largest magnitude ----------------
    logic [SUM_W-1:0] mag3_reg [4];
    logic [3:0]       neg3_reg;
    logic             zero3_reg;
    logic [MSB_W-1:0] msb3_reg;
    logic [MSB_W-1:0] msb3_next;
    logic             zero3_next;

    always_comb begin
        logic [SUM_W-1:0] orv;
        orv = mag2_reg[0] | mag2_reg[1] | mag2_reg[2] | mag2_reg[3];
        zero3_next = (orv == '0);
        msb3_next  = '0;
        for (int i = 0; i < SUM_W; i++) begin
            if (orv[i]) msb3_next = MSB_W'(i);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mag3_reg  <= mag2_reg;
            neg3_reg  <= neg2_reg;
            zero3_reg <= zero3_next;
            msb3_reg  <= msb3_next;
        end
    end

    // ---------------- stage 4: block scaling ----------------
    carry_t c4_reg;
    carry_t c4_next;

    always_comb begin
        logic [SH_W-1:0] w;
        c4_next.neg  = neg3_reg;
        c4_next.zero = zero3_reg;
        for (int k = 0; k < 4; k++) begin
            w = SH_W'(mag3_reg[k]);
            if (msb3_reg > MSB_W'(NORM_TOP)) begin
                w = w >> (msb3_reg - MSB_W'(NORM_TOP));
            end else begin
                w = w << (MSB_W'(NORM_TOP) - msb3_reg);
            end
            c4_next.m[k] = w[NORM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) c4_reg <= c4_next;
    end

    // ---------------- stages 5 to 7: sum of squares ----------------
    logic [SQ_W-1:0]   sq5_reg [4];
    carry_t            c5_reg;
    logic [SQ_W:0]     ps6_reg [2];
    carry_t            c6_reg;
    logic [SSUM_W-1:0] s7_reg;
    carry_t            c7_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                sq5_reg[k] <= c4_reg.m[k] * c4_reg.m[k];
            end
            c5_reg     <= c4_reg;
            ps6_reg[0] <= (SQ_W+1)'(sq5_reg[0]) + (SQ_W+1)'(sq5_reg[1]);
            ps6_reg[1] <= (SQ_W+1)'(sq5_reg[2]) + (SQ_W+1)'(sq5_reg[3]);
            c6_reg     <= c5_reg;
            s7_reg     <= SSUM_W'(ps6_reg[0]) + SSUM_W'(ps6_reg[1]);
            c7_reg     <= c6_reg;
        end
    end

    // ---------------- square root: one root bit per stage ----------------
    logic [REM_W-1:0]  sr_rem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0] sr_root_reg [ROOT_W+1];
    carry_t            sr_c_reg    [ROOT_W+1];

    always_comb begin
        sr_rem_reg[0]  = REM_W'(s7_reg);
        sr_root_reg[0] = '0;
        sr_c_reg[0]    = c7_reg;
    end

    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        localparam int BI = ROOT_W - 1 - k;
        logic [REM_W-1:0] delta;
        logic             take;

        // Trial: does setting this root bit keep root^2 within the sum
        assign delta = (REM_W'(sr_root_reg[k]) << (BI + 1)) | (REM_W'(1) << (2 * BI));
        assign take  = (sr_rem_reg[k] >= delta);

        always_ff @(posedge aclk) begin
            if (adv) begin
                sr_rem_reg[k+1]  <= take ? (sr_rem_reg[k] - delta) : sr_rem_reg[k];
                sr_root_reg[k+1] <= sr_root_reg[k] | (ROOT_W'(take) << BI);
                sr_c_reg[k+1]    <= sr_c_reg[k];
            end
        end
    end

    // ---------------- numerator with half-length rounding term ----------------
    logic [DIV_W-1:0]  dv_rem_reg [Q_W+1][4];
    logic [Q_W-1:0]    dv_q_reg   [Q_W+1][4];
    logic [ROOT_W-1:0] dv_len_reg [Q_W+1];
    logic [3:0]        dv_neg_reg [Q_W+1];
    logic              dv_zero_reg [Q_W+1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 4; k++) begin
                dv_rem_reg[0][k] <= (DIV_W'(sr_c_reg[ROOT_W].m[k]) << FB)
                                  + DIV_W'(sr_root_reg[ROOT_W] >> 1);
                dv_q_reg[0][k]   <= '0;
            end
            dv_len_reg[0]  <= sr_root_reg[ROOT_W];
            dv_neg_reg[0]  <= sr_c_reg[ROOT_W].neg;
            dv_zero_reg[0] <= sr_c_reg[ROOT_W].zero;
        end
    end

    // ---------------- division: one quotient bit per stage, four lanes ----------------
    for (genvar j = 0; j < Q_W; j++) begin : g_div
        localparam int BJ = Q_W - 1 - j;
        logic [DIV_W-1:0] dsh;

        assign dsh = DIV_W'(dv_len_reg[j]) << BJ;

        always_ff @(posedge aclk) begin
            if (adv) begin
                for (int k = 0; k < 4; k++) begin
                    if (dv_rem_reg[j][k] >= dsh) begin
                        dv_rem_reg[j+1][k] <= dv_rem_reg[j][k] - dsh;
                        dv_q_reg[j+1][k]   <= dv_q_reg[j][k] | (Q_W'(1) << BJ);
                    end else begin
                        dv_rem_reg[j+1][k] <= dv_rem_reg[j][k];
                        dv_q_reg[j+1][k]   <= dv_q_reg[j][k];
                    end
                end
                dv_len_reg[j+1]  <= dv_len_reg[j];
                dv_neg_reg[j+1]  <= dv_neg_reg[j];
                dv_zero_reg[j+1] <= dv_zero_reg[j];
            end
        end
    end

    // ---------------- output: saturate, restore sign, zero case ----------------
    logic [63:0] out_data_reg;
    logic        out_zero_reg;
    logic [63:0] out_data_next;

    always_comb begin
        logic [Q_W-1:0] r;
        logic [CW-1:0]  c;
        for (int k = 0; k < 4; k++) begin
            r = dv_q_reg[Q_W][k];
            if (r > LIMIT_Q) r = LIMIT_Q;
            c = CW'(r);
            if (dv_neg_reg[Q_W][k]) c = CW'(0) - c;
            if (dv_zero_reg[Q_W]) c = '0;
            out_data_next[k*CW +: CW] = c;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_data_reg <= out_data_next;
            out_zero_reg <= dv_zero_reg[Q_W];
        end
    end

    assign m_tdata = out_data_reg;
    assign m_tuser = out_zero_reg;

    // ---------------- assertions ----------------
    a_zero_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 64'd0)
        else $error("zero length result carries non-zero components");

    a_w_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd16384)
                  && ($signed(m_tdata[15:0]) >= -16'sd16384))
        else $error("prod_w outside unit range");

    a_root_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[ST_DIV] && !dv_zero_reg[0] |-> dv_len_reg[0] >= (ROOT_W'(1) << NORM_TOP))
        else $error("square root below scaled magnitude floor");

    a_scaled_top: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[3] && !c4_reg.zero |->
            (c4_reg.m[0][NORM_TOP] || c4_reg.m[1][NORM_TOP]
             || c4_reg.m[2][NORM_TOP] || c4_reg.m[3][NORM_TOP]))
        else $error("block scaling left no magnitude at the top bit");

endmodule
